### hdl/dor_pkg.sv
// ----------------------------------------------------------------------------
// dor_pkg
// Shared types, constants and reply template functions for the DHCP
// offer/ack responder.
// ----------------------------------------------------------------------------
package dor_pkg;

	localparam int unsigned MAX_MESSAGE_BYTES = 1024;
	localparam int unsigned HEADER_BYTES      = 236;
	localparam int unsigned HDR_AW            = $clog2(HEADER_BYTES);
	localparam int unsigned CNT_W             = 16;

	localparam logic [CNT_W-1:0] MAX_BYTES     = CNT_W'(MAX_MESSAGE_BYTES);
	localparam logic [CNT_W-1:0] HDR_END       = CNT_W'(HEADER_BYTES);
	localparam logic [CNT_W-1:0] OPTIONS_START = CNT_W'(240);

	localparam logic [7:0] OPT_END      = 8'd255;
	localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
	localparam logic [7:0] OPT_SERVER   = 8'd54;
	localparam logic [7:0] OPT_MASK     = 8'd1;
	localparam logic [7:0] OPT_BCAST    = 8'd28;
	localparam logic [7:0] OPT_LEASE    = 8'd51;
	localparam logic [7:0] OP_REPLY     = 8'h02;
	localparam logic [7:0] TYPE_DISCOVER = 8'd1;
	localparam logic [7:0] TYPE_REQUEST  = 8'd3;
	localparam logic [7:0] TYPE_OFFER    = 8'd2;
	localparam logic [7:0] TYPE_ACK      = 8'd5;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SERVER  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFERED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BCAST   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEASE   = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_NOREPLY = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	typedef struct packed {
		logic [31:0] server_address;
		logic [31:0] offered_address;
		logic [31:0] subnet_mask;
		logic [31:0] broadcast_address;
		logic [31:0] lease_seconds;
	} cfg_t;

	function automatic logic [7:0] addr_byte(logic [31:0] v, logic [1:0] k);
		logic [7:0] b;
		case (k)
			2'd0:    b = v[31:24];
			2'd1:    b = v[23:16];
			2'd2:    b = v[15:8];
			default: b = v[7:0];
		endcase
		return b;
	endfunction

	// True where the reply byte comes from the stored request header.
	function automatic logic from_header(logic [CNT_W-1:0] r);
		return (r != '0) && !(r >= CNT_W'(16) && r < CNT_W'(24)) && (r < HDR_END);
	endfunction

	function automatic logic [7:0] reply_fixed(logic [CNT_W-1:0] r, logic [7:0] ft,
		cfg_t cfg);
		logic [CNT_W-1:0] k;
		logic [CNT_W-1:0] d9;
		logic [CNT_W-1:0] d15;
		logic [CNT_W-1:0] d21;
		logic [CNT_W-1:0] d27;
		logic             known;
		logic [7:0]       b;
		k     = r - HDR_END;
		d9    = k - CNT_W'(9);
		d15   = k - CNT_W'(15);
		d21   = k - CNT_W'(21);
		d27   = k - CNT_W'(27);
		known = (ft == TYPE_DISCOVER) || (ft == TYPE_REQUEST);
		b     = '0;
		if (r == '0) begin
			b = OP_REPLY;
		end else if (r >= CNT_W'(16) && r < CNT_W'(20)) begin
			b = addr_byte(cfg.offered_address, r[1:0]);
		end else if (r >= CNT_W'(20) && r < CNT_W'(24)) begin
			b = addr_byte(cfg.server_address, r[1:0]);
		end else if (r >= HDR_END) begin
			if (k == CNT_W'(0) || k == CNT_W'(3)) begin
				b = 8'd99;
			end else if (k == CNT_W'(1)) begin
				b = 8'd130;
			end else if (k == CNT_W'(2)) begin
				b = 8'd83;
			end else if (k == CNT_W'(4)) begin
				b = known ? OPT_MSG_TYPE : 8'd0;
			end else if (k == CNT_W'(5)) begin
				b = known ? 8'd1 : 8'd0;
			end else if (k == CNT_W'(6)) begin
				b = (ft == TYPE_DISCOVER) ? TYPE_OFFER :
					((ft == TYPE_REQUEST) ? TYPE_ACK : 8'd0);
			end else if (k == CNT_W'(7)) begin
				b = OPT_SERVER;
			end else if (k == CNT_W'(13)) begin
				b = OPT_MASK;
			end else if (k == CNT_W'(19)) begin
				b = OPT_BCAST;
			end else if (k == CNT_W'(25)) begin
				b = OPT_LEASE;
			end else if (k == CNT_W'(8) || k == CNT_W'(14) || k == CNT_W'(20)
				|| k == CNT_W'(26)) begin
				b = 8'd4;
			end else if (k == CNT_W'(31)) begin
				b = OPT_END;
			end else if (k >= CNT_W'(9) && k < CNT_W'(13)) begin
				b = addr_byte(cfg.server_address, d9[1:0]);
			end else if (k >= CNT_W'(15) && k < CNT_W'(19)) begin
				b = addr_byte(cfg.subnet_mask, d15[1:0]);
			end else if (k >= CNT_W'(21) && k < CNT_W'(25)) begin
				b = addr_byte(cfg.broadcast_address, d21[1:0]);
			end else if (k >= CNT_W'(27) && k < CNT_W'(31)) begin
				b = addr_byte(cfg.lease_seconds, d27[1:0]);
			end
		end
		return b;
	endfunction

endpackage

### hdl/dhcp_offer_ack_responder.sv
// ----------------------------------------------------------------------------
// dhcp_offer_ack_responder
// Collects a DHCP request byte by byte, finds its message type option and
// plays back an offer or ack reply of the same length, up to MAX_MESSAGE_BYTES.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle while the output does not stall. Its
// result is registered in the first stage, together with the read of the
// header store, and then in the output register. The header store has a
// single read port and a single write port, and each item uses at most one
// of them, so no two items ever touch the same entry in the same cycle.
module dhcp_offer_ack_responder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [7:0]                    data_byte,
	input  logic                          last_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    reply_byte,
	output logic                          reply_last,
	output logic [1:0]                    status,
	output logic [7:0]                    message_type,
	input  logic                          cfg_we,
	input  logic [dor_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import dor_pkg::*;

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_TYPE,
		PH_FOUND,
		PH_END
	} phase_t;

	cfg_t             cfg_q;
	logic [CNT_W-1:0] count_q, count_n;
	logic [CNT_W-1:0] nto_q, nto_n;
	phase_t           phase_q, phase_n;
	logic [7:0]       ft_q, ft_n;
	logic             pending_q, pending_n;
	logic [CNT_W-1:0] rpos_q, rpos_n;

	logic             accept;
	logic             s1_adv;
	logic             s1_valid_q;
	logic             s1_mem_s1;
	logic [7:0]       s1_byte_s1;
	logic             s1_last_s1;
	logic [1:0]       s1_status_s1;
	logic [7:0]       s1_mtype_s1;

	logic             out_valid_q;
	logic [7:0]       reply_byte_q;
	logic             reply_last_q;
	logic [1:0]       status_q;
	logic [7:0]       mtype_q;

	logic             wr_en, rd_en, use_mem;
	logic [7:0]       fixed_byte, mtype_c, rd_data;
	logic             rlast_c;
	logic [1:0]       status_c;
	logic [CNT_W-1:0] pos;
	logic [CNT_W+1:0] nxt;
	logic [CNT_W:0]   nto_p1, nto_p2;

	assign accept   = in_valid && in_ready;
	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;

	always_comb begin
		count_n    = count_q;
		nto_n      = nto_q;
		phase_n    = phase_q;
		ft_n       = ft_q;
		pending_n  = pending_q;
		rpos_n     = rpos_q;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		use_mem    = 1'b0;
		fixed_byte = '0;
		rlast_c    = 1'b0;
		status_c   = ST_OK;
		mtype_c    = '0;
		pos        = '0;
		nxt        = '0;
		nto_p1     = '0;
		nto_p2     = '0;
		if (action) begin
			if (pending_q && rpos_q < count_q) begin
				use_mem    = from_header(rpos_q);
				rd_en      = use_mem;
				fixed_byte = reply_fixed(rpos_q, ft_q, cfg_q);
				rpos_n     = rpos_q + CNT_W'(1);
				if (rpos_n >= count_q) begin
					rlast_c   = 1'b1;
					count_n   = '0;
					nto_n     = OPTIONS_START;
					phase_n   = PH_SEARCH;
					ft_n      = '0;
					pending_n = 1'b0;
					rpos_n    = '0;
				end
			end else begin
				status_c = ST_EMPTY;
			end
		end else begin
			if (pending_q) begin
				count_n   = '0;
				nto_n     = OPTIONS_START;
				phase_n   = PH_SEARCH;
				ft_n      = '0;
				pending_n = 1'b0;
				rpos_n    = '0;
			end
			pos    = count_n;
			nto_p1 = {1'b0, nto_n} + (CNT_W+1)'(1);
			nto_p2 = {1'b0, nto_n} + (CNT_W+1)'(2);
			nxt    = {2'b00, pos} + {{(CNT_W-6){1'b0}}, data_byte} + (CNT_W+2)'(1);
			if (pos < MAX_BYTES) begin
				wr_en = (pos < HDR_END);
				if (phase_n == PH_SEARCH) begin
					if (pos == nto_n) begin
						if (data_byte == OPT_END) begin
							phase_n = PH_END;
						end else if (data_byte == OPT_MSG_TYPE) begin
							phase_n = PH_TYPE;
						end
					end else if ({1'b0, pos} == nto_p1) begin
						nto_n = (nxt[CNT_W+1:CNT_W] != 2'b00) ? '1 : nxt[CNT_W-1:0];
					end
				end else if (phase_n == PH_TYPE) begin
					if ({1'b0, pos} == nto_p2) begin
						ft_n    = data_byte;
						phase_n = PH_FOUND;
					end
				end
				count_n = pos + CNT_W'(1);
			end
			if (last_byte) begin
				if (phase_n == PH_FOUND) begin
					status_c  = ST_READY;
					mtype_c   = ft_n;
					pending_n = 1'b1;
					rpos_n    = '0;
				end else begin
					status_c  = ST_NOREPLY;
					count_n   = '0;
					nto_n     = OPTIONS_START;
					phase_n   = PH_SEARCH;
					ft_n      = '0;
					pending_n = 1'b0;
					rpos_n    = '0;
				end
			end
		end
	end

	dor_hdr_store u_hdr (
		.clk     (clk),
		.wr_en   (accept && !action && wr_en),
		.wr_addr (pos[HDR_AW-1:0]),
		.wr_data (data_byte),
		.rd_en   (accept && rd_en),
		.rd_addr (rpos_q[HDR_AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.server_address    <= 32'd3232238081;
			cfg_q.offered_address   <= 32'd3232238082;
			cfg_q.subnet_mask       <= 32'd4294967040;
			cfg_q.broadcast_address <= 32'd3232238335;
			cfg_q.lease_seconds     <= 32'd86400;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SERVER:  cfg_q.server_address    <= cfg_data;
				REG_OFFERED: cfg_q.offered_address   <= cfg_data;
				REG_MASK:    cfg_q.subnet_mask       <= cfg_data;
				REG_BCAST:   cfg_q.broadcast_address <= cfg_data;
				REG_LEASE:   cfg_q.lease_seconds     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			nto_q     <= OPTIONS_START;
			phase_q   <= PH_SEARCH;
			ft_q      <= '0;
			pending_q <= 1'b0;
			rpos_q    <= '0;
		end else if (accept) begin
			count_q   <= count_n;
			nto_q     <= nto_n;
			phase_q   <= phase_n;
			ft_q      <= ft_n;
			pending_q <= pending_n;
			rpos_q    <= rpos_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_mem_s1    <= use_mem;
			s1_byte_s1   <= fixed_byte;
			s1_last_s1   <= rlast_c;
			s1_status_s1 <= status_c;
			s1_mtype_s1  <= mtype_c;
		end
		if (s1_adv) begin
			reply_byte_q <= s1_mem_s1 ? rd_data : s1_byte_s1;
			reply_last_q <= s1_last_s1;
			status_q     <= s1_status_s1;
			mtype_q      <= s1_mtype_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign reply_byte   = reply_byte_q;
	assign reply_last   = reply_last_q;
	assign status       = status_q;
	assign message_type = mtype_q;

endmodule

### hdl/dor_hdr_store.sv
// ----------------------------------------------------------------------------
// dor_hdr_store
// Synchronous store for the fixed request header, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module dor_hdr_store (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [dor_pkg::HDR_AW-1:0] wr_addr,
	input  logic [7:0]                 wr_data,
	input  logic                       rd_en,
	input  logic [dor_pkg::HDR_AW-1:0] rd_addr,
	output logic [7:0]                 rd_data
);
	import dor_pkg::*;

	logic [7:0] mem [HEADER_BYTES];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### test/dhcp_offer_ack_responder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_offer_ack_responder_test
// Self-checking testbench for the DHCP offer/ack responder. Requests are
// streamed in byte by byte and replies read back. Directed items carry fixed
// expected results; the rest are predicted by a behavioural model of the
// option walk and the reply template. Results are compared in order, under
// random idling on both sides, a long receiver hold-off and an oversize request.
// ----------------------------------------------------------------------------
module dhcp_offer_ack_responder_test;
	import dor_pkg::*;

	localparam logic ACT_RX   = 1'b0;
	localparam logic ACT_READ = 1'b1;

	localparam logic [31:0] MAGIC_COOKIE   = 32'h63825363;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned QUIET_LIMIT    = 3000;
	localparam int unsigned MAX_REPORTS    = 10;
	localparam int unsigned OVERSIZE_READS = 48;

	typedef struct packed {
		logic [7:0] rbyte;
		logic       rlast;
		logic [1:0] st;
		logic [7:0] mtype;
	} responder_out_t;

	typedef struct {
		logic           act;
		logic [7:0]     b;
		logic           lst;
		bit             typed;
		responder_out_t want;
	} plan_row_t;

	typedef enum logic [1:0] {WALK_SEARCH, WALK_TYPE, WALK_FOUND, WALK_END} walk_t;
	typedef enum {KIND_OFFER, KIND_EARLY_END, KIND_END_FIRST, KIND_JUNK, KIND_SHORT}
		request_kind_t;

	localparam responder_out_t EMPTY_READ = {8'd0, 1'b0, ST_EMPTY, 8'd0};
	localparam responder_out_t COLLECTING = {8'd0, 1'b0, ST_OK, 8'd0};
	localparam responder_out_t REFUSED    = {8'd0, 1'b0, ST_NOREPLY, 8'd0};

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 action;
	logic [7:0]           data_byte;
	logic                 last_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [7:0]           reply_byte;
	logic                 reply_last;
	logic [1:0]           status;
	logic [7:0]           message_type;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	// Behavioural copy of the responder state.
	logic [7:0]  hdr_mem [0:HEADER_BYTES-1];
	int unsigned rx_count;
	int unsigned tag_at;
	walk_t       phase;
	logic [7:0]  seen_type;
	bit          pending;
	int unsigned rd_pos;
	cfg_t        cfg_now;

	responder_out_t awaited [$];
	logic [7:0]     req_bytes [$];

	int unsigned in_idle_pct;
	int unsigned out_idle_pct;
	int unsigned hold_asks;
	int unsigned items_sent;
	int unsigned err_count;
	int unsigned quiet;
	int unsigned n_ready;
	int unsigned n_refused;
	int unsigned n_reply_bytes;
	int unsigned n_empty;

	plan_row_t plan [11] = '{
		'{ACT_READ, 8'hFF, 1'b1, 1'b1, EMPTY_READ},
		'{ACT_READ, 8'h00, 1'b0, 1'b1, EMPTY_READ},
		'{ACT_RX,   8'h00, 1'b0, 1'b1, COLLECTING},
		'{ACT_RX,   8'hFF, 1'b0, 1'b1, COLLECTING},
		'{ACT_RX,   8'hAA, 1'b1, 1'b1, REFUSED},
		'{ACT_READ, 8'h55, 1'b1, 1'b1, EMPTY_READ},
		'{ACT_RX,   8'hFF, 1'b1, 1'b1, REFUSED},
		'{ACT_RX,   8'h35, 1'b0, 1'b0, '0},
		'{ACT_RX,   8'h01, 1'b0, 1'b0, '0},
		'{ACT_RX,   8'h00, 1'b1, 1'b1, REFUSED},
		'{ACT_READ, 8'h00, 1'b0, 1'b1, EMPTY_READ}
	};

	dhcp_offer_ack_responder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.reply_byte   (reply_byte),
		.reply_last   (reply_last),
		.status       (status),
		.message_type (message_type),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] ip_octet(logic [31:0] v, int unsigned k);
		return v[8 * (3 - k) +: 8];
	endfunction

	function automatic void clear_walk();
		rx_count  = 0;
		tag_at    = OPTIONS_START;
		phase     = WALK_SEARCH;
		seen_type = 8'd0;
		pending   = 1'b0;
		rd_pos    = 0;
	endfunction

	function automatic logic [7:0] offer_octet(int unsigned r);
		int unsigned k;
		bit          known;
		k     = r - HEADER_BYTES;
		known = (seen_type == TYPE_DISCOVER) || (seen_type == TYPE_REQUEST);
		if (r == 0)
			return OP_REPLY;
		if (r >= 16 && r < 20)
			return ip_octet(cfg_now.offered_address, r - 16);
		if (r >= 20 && r < 24)
			return ip_octet(cfg_now.server_address, r - 20);
		if (r < HEADER_BYTES)
			return hdr_mem[r];
		case (k)
			0, 1, 2, 3:     return ip_octet(MAGIC_COOKIE, k);
			4:              return known ? OPT_MSG_TYPE : 8'd0;
			5:              return known ? 8'd1 : 8'd0;
			6:              return (seen_type == TYPE_DISCOVER) ? TYPE_OFFER :
				((seen_type == TYPE_REQUEST) ? TYPE_ACK : 8'd0);
			7:              return OPT_SERVER;
			13:             return OPT_MASK;
			19:             return OPT_BCAST;
			25:             return OPT_LEASE;
			8, 14, 20, 26:  return 8'd4;
			31:             return OPT_END;
			9, 10, 11, 12:  return ip_octet(cfg_now.server_address, k - 9);
			15, 16, 17, 18: return ip_octet(cfg_now.subnet_mask, k - 15);
			21, 22, 23, 24: return ip_octet(cfg_now.broadcast_address, k - 21);
			27, 28, 29, 30: return ip_octet(cfg_now.lease_seconds, k - 27);
			default:        return 8'd0;
		endcase
	endfunction

	function automatic void take_octet(int unsigned pos, logic [7:0] b);
		int unsigned nxt;
		if (pos < HEADER_BYTES)
			hdr_mem[pos] = b;
		case (phase)
			WALK_SEARCH: begin
				if (pos == tag_at) begin
					if (b == OPT_END)
						phase = WALK_END;
					else if (b == OPT_MSG_TYPE)
						phase = WALK_TYPE;
				end else if (pos == tag_at + 1) begin
					nxt    = pos + b + 1;
					tag_at = (nxt > 32'hFFFF) ? 32'hFFFF : nxt;
				end
			end
			WALK_TYPE: begin
				if (pos == tag_at + 2) begin
					seen_type = b;
					phase     = WALK_FOUND;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic responder_out_t forecast(logic act, logic [7:0] b, logic lst);
		responder_out_t o;
		o = '0;
		if (act == ACT_READ) begin
			if (pending && rd_pos < rx_count) begin
				o.rbyte = offer_octet(rd_pos);
				rd_pos++;
				if (rd_pos >= rx_count) begin
					o.rlast = 1'b1;
					clear_walk();
				end
			end else begin
				o.st = ST_EMPTY;
			end
		end else begin
			if (pending)
				clear_walk();
			if (rx_count < MAX_MESSAGE_BYTES) begin
				take_octet(rx_count, b);
				rx_count++;
			end
			if (lst) begin
				if (phase == WALK_FOUND) begin
					o.st    = ST_READY;
					o.mtype = seen_type;
					pending = 1'b1;
					rd_pos  = 0;
				end else begin
					o.st = ST_NOREPLY;
					clear_walk();
				end
			end
		end
		return o;
	endfunction

	task automatic push_item(input logic act, input logic [7:0] b, input logic lst,
		input bit given_ok, input responder_out_t given);
		responder_out_t want;
		bit             taken;
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		data_byte <= b;
		last_byte <= lst;
		do begin
			@(negedge clk);
			taken = in_ready;
		end while (!taken);
		want = forecast(act, b, lst);
		if (act == ACT_READ && want.st == ST_OK)
			n_reply_bytes++;
		if (want.st == ST_EMPTY)
			n_empty++;
		if (want.st == ST_READY)
			n_ready++;
		if (want.st == ST_NOREPLY)
			n_refused++;
		awaited.push_back(given_ok ? given : want);
		items_sent++;
		@(posedge clk);
	endtask

	task automatic drain_and_wait();
		in_valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		case (idx)
			REG_SERVER:  cfg_now.server_address    = d;
			REG_OFFERED: cfg_now.offered_address   = d;
			REG_MASK:    cfg_now.subnet_mask       = d;
			REG_BCAST:   cfg_now.broadcast_address = d;
			REG_LEASE:   cfg_now.lease_seconds     = d;
			default: ;
		endcase
	endtask

	task automatic load_settings(input cfg_t v);
		put_reg(REG_SERVER, v.server_address);
		put_reg(REG_OFFERED, v.offered_address);
		put_reg(REG_MASK, v.subnet_mask);
		put_reg(REG_BCAST, v.broadcast_address);
		put_reg(REG_LEASE, v.lease_seconds);
		cfg_we <= 1'b0;
	endtask

	function automatic void add_filler();
		logic [7:0]  tag;
		int unsigned n;
		do
			tag = 8'($urandom);
		while (tag == OPT_MSG_TYPE || tag == OPT_END);
		if ($urandom_range(3) == 0)
			tag = 8'd0;
		n = $urandom_range(0, 6);
		req_bytes.push_back(tag);
		req_bytes.push_back(8'(n));
		repeat (n) req_bytes.push_back(8'($urandom));
	endfunction

	function automatic void compose_request(request_kind_t kind, int unsigned pad_to);
		int unsigned i;
		int unsigned n;
		int unsigned len;
		int unsigned type_at;
		int unsigned pick;
		req_bytes.delete();
		if (kind == KIND_SHORT) begin
			n = $urandom_range(1, 24);
			repeat (n) req_bytes.push_back(8'($urandom));
			return;
		end
		for (i = 0; i < HEADER_BYTES; i++)
			req_bytes.push_back(8'($urandom));
		for (i = 0; i < 4; i++)
			req_bytes.push_back(($urandom_range(3) == 0) ? 8'($urandom)
				: ip_octet(MAGIC_COOKIE, i));
		if (kind == KIND_JUNK) begin
			n = $urandom_range(0, 80);
			repeat (n) req_bytes.push_back(8'($urandom));
			return;
		end
		n = $urandom_range(0, 3);
		repeat (n) add_filler();
		if (kind == KIND_END_FIRST)
			req_bytes.push_back(OPT_END);
		type_at = req_bytes.size();
		req_bytes.push_back(OPT_MSG_TYPE);
		len = ($urandom_range(9) == 0) ? $urandom_range(0, 6) : 1;
		req_bytes.push_back(8'(len));
		pick = $urandom_range(9);
		req_bytes.push_back((pick < 4) ? TYPE_DISCOVER :
			((pick < 8) ? TYPE_REQUEST : 8'($urandom)));
		if (len > 1)
			repeat (len - 1) req_bytes.push_back(8'($urandom));
		n = $urandom_range(0, 2);
		repeat (n) add_filler();
		if ($urandom_range(4) != 0)
			req_bytes.push_back(OPT_END);
		n = $urandom_range(0, 12);
		repeat (n) req_bytes.push_back(8'd0);
		while (req_bytes.size() < pad_to)
			req_bytes.push_back(8'($urandom));
		if (kind == KIND_EARLY_END) begin
			len = type_at + $urandom_range(1, 2);
			while (req_bytes.size() > len)
				void'(req_bytes.pop_back());
		end
	endfunction

	// A read cap of zero lets the number of reply bytes read be chosen at random.
	task automatic run_exchange(input int unsigned read_cap);
		int unsigned i;
		int unsigned left;
		int unsigned cut;
		for (i = 0; i < req_bytes.size(); i++)
			push_item(ACT_RX, req_bytes[i], i == req_bytes.size() - 1, 1'b0, '0);
		if (pending) begin
			left = rx_count - rd_pos;
			if (read_cap != 0)
				cut = (left < read_cap) ? left : read_cap;
			else
				cut = ($urandom_range(99) < 70) ? left : $urandom_range(1, left - 1);
			repeat (cut) push_item(ACT_READ, 8'($urandom), 1'($urandom), 1'b0, '0);
		end
		if ($urandom_range(99) < 30)
			repeat ($urandom_range(1, 3))
				push_item(ACT_READ, 8'($urandom), 1'($urandom), 1'b0, '0);
	endtask

	task automatic random_exchange();
		int unsigned   pick;
		request_kind_t kind;
		pick = $urandom_range(99);
		if (pick < 55)
			kind = KIND_OFFER;
		else if (pick < 68)
			kind = KIND_EARLY_END;
		else if (pick < 76)
			kind = KIND_END_FIRST;
		else if (pick < 88)
			kind = KIND_JUNK;
		else
			kind = KIND_SHORT;
		compose_request(kind, 0);
		run_exchange(0);
	endtask

	// Receiver side: random idling, plus one long hold-off when asked for.
	initial begin : receiver
		int unsigned hold_done;
		int unsigned hold_left;
		hold_done = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_done != hold_asks) begin
				hold_done = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= out_idle_pct);
			end
		end
	end

	always @(negedge clk) begin : result_check
		responder_out_t got;
		responder_out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = {reply_byte, reply_last, status, message_type};
				if (awaited.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("Unexpected result: byte %0d last %0b status %0d type %0d",
							got.rbyte, got.rlast, got.st, got.mtype);
				end else begin
					want = awaited.pop_front();
					if (got !== want) begin
						err_count++;
						if (err_count <= MAX_REPORTS) begin
							$display("Mismatch: expected byte %0d last %0b status %0d type %0d",
								want.rbyte, want.rlast, want.st, want.mtype);
							$display("          got byte %0d last %0b status %0d type %0d",
								got.rbyte, got.rlast, got.st, got.mtype);
						end
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
					$display("dhcp_offer_ack_responder test failed");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		cfg_t        v;
		int unsigned goal;
		in_valid      <= 1'b0;
		action        <= ACT_RX;
		data_byte     <= 8'd0;
		last_byte     <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_SERVER;
		cfg_data      <= 32'd0;
		arst_n        <= 1'b0;
		in_idle_pct   = 24;
		out_idle_pct  = 54;
		hold_asks     = 0;
		items_sent    = 0;
		err_count     = 0;
		quiet         = 0;
		n_ready       = 0;
		n_refused     = 0;
		n_reply_bytes = 0;
		n_empty       = 0;
		clear_walk();
		cfg_now.server_address    = 32'hC0A80A01;
		cfg_now.offered_address   = 32'hC0A80A02;
		cfg_now.subnet_mask       = 32'hFFFFFF00;
		cfg_now.broadcast_address = 32'hC0A80AFF;
		cfg_now.lease_seconds     = 32'd86400;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			push_item(plan[i].act, plan[i].b, plan[i].lst, plan[i].typed, plan[i].want);

		drain_and_wait();
		load_settings('0);
		goal = items_sent + 150;
		while (items_sent < goal)
			random_exchange();

		drain_and_wait();
		load_settings('1);
		in_idle_pct  = 54;
		out_idle_pct = 24;
		goal = items_sent + 150;
		while (items_sent < goal)
			random_exchange();

		drain_and_wait();
		v.server_address    = $urandom;
		v.offered_address   = $urandom;
		v.subnet_mask       = $urandom;
		v.broadcast_address = $urandom;
		v.lease_seconds     = $urandom;
		load_settings(v);
		in_idle_pct  = 0;
		out_idle_pct = 0;
		hold_asks++;
		// Oversize request: the tail beyond the size limit is dropped.
		compose_request(KIND_OFFER, MAX_MESSAGE_BYTES + 6);
		run_exchange(OVERSIZE_READS);

		drain_and_wait();
		err_count += awaited.size();
		$display("Covered %0d transfers: %0d replies made ready, %0d requests refused,",
			items_sent, n_ready, n_refused);
		$display("%0d reply bytes read, %0d reads with nothing pending, %0d mismatches.",
			n_reply_bytes, n_empty, err_count);
		if (err_count == 0)
			$display("dhcp_offer_ack_responder test passed");
		else
			$display("dhcp_offer_ack_responder test failed");
		$finish;
	end

endmodule
